>>> hw/rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types and constants for the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned VAL_W = 31;
  localparam logic [VAL_W-1:0] MOD_RESET = 31'd998244353;

  typedef struct packed {
    logic load;
    logic shift;
  } ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_GO,
    S_RED_WT,
    S_CHK,
    S_MUL_GO,
    S_MUL_WT,
    S_SQ_GO,
    S_SQ_WT
  } state_t;

endpackage

>>> hw/rtl/mexp_cell.sv
// ----------------------------------------------------------------------------
// mexp_cell
// one exponent bit cell, shifts toward the lsb neighbor
// ----------------------------------------------------------------------------
module mexp_cell (
  input  logic          clk,
  input  mexp_pkg::ctl_t ctl,
  input  logic          load_bit,
  input  logic          next_bit,
  output logic          bit_q
);

  logic bit_r;
  logic bit_nxt;

  always_comb begin
    bit_nxt = bit_r;
    if (ctl.load) begin
      bit_nxt = load_bit;
    end else if (ctl.shift) begin
      bit_nxt = next_bit;
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
  end

  assign bit_q = bit_r;

endmodule

>>> hw/rtl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// interleaved shift-add modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module mexp_mulmod #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [MOD_BITS-1:0]       op_a,
  input  logic [mexp_pkg::VAL_W-1:0] op_b,
  input  logic [MOD_BITS-1:0]       modulus,
  output logic                      done,
  output logic [MOD_BITS-1:0]       product
);

  localparam int unsigned CNT_W = $clog2(mexp_pkg::VAL_W);
  localparam int unsigned ACC_W = MOD_BITS + 2;

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [mexp_pkg::VAL_W-1:0] b_r, b_nxt;
  logic [MOD_BITS-1:0]        a_r, a_nxt;
  logic [MOD_BITS-1:0]        r_r, r_nxt;
  logic [ACC_W-1:0]           sum;
  logic [ACC_W-1:0]           sub1;
  logic [ACC_W-1:0]           sub2;
  logic [ACC_W-1:0]           m_ext;

  assign m_ext = {2'b00, modulus};

  always_comb begin
    sum  = {1'b0, r_r, 1'b0} + (b_r[mexp_pkg::VAL_W-1] ? {2'b00, a_r} : '0);
    sub1 = (sum >= m_ext) ? sum - m_ext : sum;
    sub2 = (sub1 >= m_ext) ? sub1 - m_ext : sub1;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    b_nxt    = b_r;
    a_nxt    = a_r;
    r_nxt    = r_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(mexp_pkg::VAL_W - 1);
      b_nxt    = op_b;
      a_nxt    = op_a;
      r_nxt    = '0;
    end else if (busy_r) begin
      r_nxt = sub2[MOD_BITS-1:0];
      b_nxt = {b_r[mexp_pkg::VAL_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    b_r   <= b_nxt;
    a_r   <= a_nxt;
    r_r   <= r_nxt;
  end

  assign done    = done_r;
  assign product = r_r;

endmodule

>>> hw/rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base_value ^ exponent mod modulus, right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// One request at a time. The exponent sits in a chain of bit cells that
// shifts one place per squaring; each multiply runs on a shared bit-serial
// modular multiplier. A request reduces the base first, then for each
// exponent bit up to the highest set one checks the bit, multiplies if it
// is set and squares; a final check with no set bits left gives the result.
// The modulus is written through cfg_wr_en/cfg_wr_data.
module modular_exponentiation #(
  parameter int unsigned EXP_BITS = 63,
  parameter int unsigned MOD_BITS = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [30:0] in_base_value,
  input  logic [62:0] in_exponent,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_remainder
);

  mexp_pkg::state_t state_r, state_nxt;

  logic [mexp_pkg::VAL_W-1:0] modulus_r;
  logic [MOD_BITS-1:0]        mod_r, mod_nxt;
  logic [MOD_BITS-1:0]        mod_eff;
  logic [mexp_pkg::VAL_W-1:0] base_r, base_nxt;
  logic [MOD_BITS-1:0]        acc_r, acc_nxt;
  logic [MOD_BITS-1:0]        sq_r, sq_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [30:0]                out_rem_r, out_rem_nxt;
  logic                       accept;
  logic                       e_zero;
  logic [EXP_BITS:0]          chain;
  mexp_pkg::ctl_t             ctl;
  logic                       mm_start;
  logic [MOD_BITS-1:0]        mm_a;
  logic [mexp_pkg::VAL_W-1:0] mm_b;
  logic                       mm_done;
  logic [MOD_BITS-1:0]        mm_p;

  assign mod_eff  = (modulus_r[MOD_BITS-1:0] == '0) ? MOD_BITS'(1) : modulus_r[MOD_BITS-1:0];
  assign in_stall = (state_r != mexp_pkg::S_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;

  // exponent bit chain
  assign chain[EXP_BITS] = 1'b0;
  for (genvar i = 0; i < EXP_BITS; i++) begin : g_cell
    mexp_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_bit (in_exponent[i]),
      .next_bit (chain[i+1]),
      .bit_q    (chain[i])
    );
  end
  assign e_zero = (chain[EXP_BITS-1:0] == '0);

  mexp_mulmod #(.MOD_BITS(MOD_BITS)) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .op_a    (mm_a),
    .op_b    (mm_b),
    .modulus (mod_r),
    .done    (mm_done),
    .product (mm_p)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mexp_pkg::S_IDLE:   if (accept) state_nxt = mexp_pkg::S_RED_GO;
      mexp_pkg::S_RED_GO: state_nxt = mexp_pkg::S_RED_WT;
      mexp_pkg::S_RED_WT: if (mm_done) state_nxt = mexp_pkg::S_CHK;
      mexp_pkg::S_CHK: begin
        priority if (e_zero) state_nxt = mexp_pkg::S_IDLE;
        else if (chain[0])   state_nxt = mexp_pkg::S_MUL_GO;
        else                 state_nxt = mexp_pkg::S_SQ_GO;
      end
      mexp_pkg::S_MUL_GO: state_nxt = mexp_pkg::S_MUL_WT;
      mexp_pkg::S_MUL_WT: if (mm_done) state_nxt = mexp_pkg::S_SQ_GO;
      mexp_pkg::S_SQ_GO:  state_nxt = mexp_pkg::S_SQ_WT;
      mexp_pkg::S_SQ_WT:  if (mm_done) state_nxt = mexp_pkg::S_CHK;
      default:            state_nxt = mexp_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    ctl           = '0;
    mm_start      = 1'b0;
    mm_a          = sq_r;
    mm_b          = mexp_pkg::VAL_W'(sq_r);
    mod_nxt       = mod_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rem_nxt   = out_rem_r;
    unique case (state_r)
      mexp_pkg::S_IDLE: begin
        if (accept) begin
          ctl.load = 1'b1;
          mod_nxt  = mod_eff;
          base_nxt = in_base_value;
          acc_nxt  = (mod_eff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
        end
      end
      mexp_pkg::S_RED_GO: begin
        mm_start = 1'b1;
        mm_a     = MOD_BITS'(1);
        mm_b     = base_r;
      end
      mexp_pkg::S_RED_WT: if (mm_done) sq_nxt = mm_p;
      mexp_pkg::S_CHK: begin
        if (e_zero) begin
          out_valid_nxt = 1'b1;
          out_rem_nxt   = 31'(acc_r);
        end
      end
      mexp_pkg::S_MUL_GO: begin
        mm_start = 1'b1;
        mm_a     = acc_r;
      end
      mexp_pkg::S_MUL_WT: if (mm_done) acc_nxt = mm_p;
      mexp_pkg::S_SQ_GO:  mm_start = 1'b1;
      mexp_pkg::S_SQ_WT: begin
        if (mm_done) begin
          sq_nxt    = mm_p;
          ctl.shift = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= mexp_pkg::MOD_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        modulus_r <= cfg_wr_data;
      end
    end
    mod_r     <= mod_nxt;
    base_r    <= base_nxt;
    acc_r     <= acc_nxt;
    sq_r      <= sq_nxt;
    out_rem_r <= out_rem_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_remainder = out_rem_r;

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_rem_r < 31'(mod_r)))
    else $error("remainder not below modulus");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mexp_pkg::S_IDLE) |-> in_stall)
    else $error("request accepted while busy");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> (state_r == mexp_pkg::S_RED_WT || state_r == mexp_pkg::S_MUL_WT ||
                 state_r == mexp_pkg::S_SQ_WT))
    else $error("multiplier done outside a wait state");
`endif

endmodule
